// ===== rtl/crxfb_pkg.sv =====
package crxfb_pkg;

  localparam int BUSES        = 4;
  localparam int PER_ID_DEPTH = 16;
  localparam int ID_SLOTS     = 16;
  localparam int ENT          = 64;
  localparam int MAX_BYTES    = 64;
  localparam int WORDS        = 8;

  localparam int BUS_W  = 2;
  localparam int ID_W   = 29;
  localparam int LEN_W  = 7;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int WORD_W = $clog2(WORDS);
  localparam int ENT_W  = $clog2(ENT);
  localparam int SLOT_W = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int BUS_N  = 1 << BUS_W;

  localparam int ASM_DEPTH  = 1 << (BUS_W + WORD_W);
  localparam int HDR_DEPTH  = 1 << (BUS_W + ENT_W);
  localparam int PAY_DEPTH  = 1 << (BUS_W + ENT_W + WORD_W);
  localparam int SLOT_DEPTH = 1 << (BUS_W + SLOT_W);

  localparam logic [1:0] KIND_RX     = 2'd0;
  localparam logic [1:0] KIND_RD_ID  = 2'd1;
  localparam logic [1:0] KIND_RD_BUS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PER_ID_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_ENABLE   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_BEAT,
    OP_READ_ID,
    OP_READ_BUS,
    OP_OFFLINE
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_OFFLINE = 2'd2
  } stat_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_BEAT, ST_SL_RD, ST_SL_CMP, ST_SL_NEW, ST_CHK,
    ST_EP_RD, ST_EP_GET, ST_CP_RD, ST_CP_WR, ST_CM_FIN, ST_CM_END,
    ST_RD_PERM, ST_RD_HDR, ST_RD_CMP, ST_OUT_RD, ST_OUT_LD,
    ST_SH_RD, ST_SH_WR, ST_DS_RD, ST_DS_CMP, ST_STAT
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [BUS_W-1:0]   bus;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } hdr_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
  } slot_t;

  // Zero every byte of word w that lies at or beyond len.
  function automatic logic [DATA_W-1:0] mask_word(logic [DATA_W-1:0] d,
                                                  logic [LEN_W-1:0] len,
                                                  logic [WORD_W-1:0] w);
    logic [DATA_W-1:0] r;
    logic [LEN_W-1:0]  pos;
    r = d;
    for (int j = 0; j < 8; j++) begin
      pos = LEN_W'({w, 3'(j)});
      if (pos >= len) r[j*8 +: 8] = 8'h00;
    end
    return r;
  endfunction

endpackage

// ===== rtl/crxfb_ram.sv =====
module crxfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/crxfb_front.sv =====
module crxfb_front
  import crxfb_pkg::*;
(
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [BUS_W-1:0]      bus_i,
  input  logic [ID_W-1:0]       can_id_i,
  input  logic [LEN_W-1:0]      length_i,
  input  logic [DATA_W-1:0]     data_word_i,
  input  logic                  beat_last_i,
  input  logic [BUSES-1:0]      bus_enable_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output cmd_t                  q_cmd_o
);

  logic online;
  logic keep;

  assign online = (32'(bus_i) < BUSES) && bus_enable_i[bus_i];

  always_comb begin
    q_cmd_o.bus  = bus_i;
    q_cmd_o.id   = can_id_i;
    q_cmd_o.len  = length_i;
    q_cmd_o.data = data_word_i;
    q_cmd_o.last = beat_last_i;
    q_cmd_o.op   = OP_BEAT;
    keep         = 1'b0;
    unique case (kind_i)
      KIND_RX: begin
        keep = online;
      end
      KIND_RD_ID: begin
        keep = 1'b1;
        q_cmd_o.op = online ? OP_READ_ID : OP_OFFLINE;
      end
      KIND_RD_BUS: begin
        keep = 1'b1;
        q_cmd_o.op = online ? OP_READ_BUS : OP_OFFLINE;
      end
      default: keep = 1'b0;
    endcase
  end

  // Dropped items are taken without entering the queue.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

// ===== rtl/crxfb_queue.sv =====
module crxfb_queue
  import crxfb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= cmd_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = buf_q[rd_q];

endmodule

// ===== rtl/crxfb_back.sv =====
module crxfb_back
  import crxfb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [BUSES-1:0]      bus_enable_o,
  input  logic                  q_valid_i,
  input  cmd_t                  q_cmd_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [ID_W-1:0]       can_id_res_o,
  output logic [LEN_W-1:0]      length_res_o,
  output logic [DATA_W-1:0]     data_word_res_o,
  output logic                  last_o
);

  localparam int AA = BUS_W + WORD_W;
  localparam int HA = BUS_W + ENT_W;
  localparam int PA = BUS_W + ENT_W + WORD_W;
  localparam int SA = BUS_W + SLOT_W;

  state_e state_q, state_d;
  cmd_t   cmd_q;

  logic [CNT_W-1:0]  limit_q;
  logic [BUSES-1:0]  enable_q;

  logic [ENT_W:0]    fill_q  [BUS_N];
  logic [2:0]        beat_q  [BUS_N];
  logic [ASM_DEPTH-1:0]  wvld_q;
  logic [SLOT_DEPTH-1:0] used_q;
  logic [HDR_DEPTH-1:0]  pvld_q;

  logic [ENT_W:0]    r_q;
  logic [SLOT_W-1:0] s_q, slot_idx_q, free_idx_q;
  logic              free_vld_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ENT_W-1:0]  ent_q;
  logic [WORD_W-1:0] w_q, beats_m1_q;
  logic [ID_W-1:0]   hdr_id_q;
  logic [LEN_W-1:0]  hdr_len_q;
  stat_e             stat_q;
  logic [HA-1:0]     perm_addr_q;
  logic [AA-1:0]     asm_addr_q;

  logic              out_valid_q, last_q;
  stat_e             status_q;
  logic [ID_W-1:0]   id_res_q;
  logic [LEN_W-1:0]  len_res_q;
  logic [DATA_W-1:0] data_res_q;

  // RAM ports
  logic              asm_we, asm_re, hdr_we, hdr_re, pay_we, pay_re;
  logic              perm_we, perm_re, slot_we, slot_re;
  logic [AA-1:0]     asm_waddr, asm_raddr;
  logic [DATA_W-1:0] asm_wdata, asm_rdata, pay_wdata, pay_rdata;
  logic [HA-1:0]     hdr_waddr, hdr_raddr, perm_waddr, perm_raddr;
  hdr_t              hdr_wdata, hdr_rdata;
  logic [PA-1:0]     pay_waddr, pay_raddr;
  logic [ENT_W-1:0]  perm_wdata, perm_rdata;
  logic [SA-1:0]     slot_waddr, slot_raddr;
  slot_t             slot_wdata, slot_rdata;

  logic [BUS_W-1:0]  bus;
  logic [ENT_W:0]    fill, r_inc;
  logic [LEN_W-1:0]  len_sat;
  logic [CNT_W-1:0]  lim;
  logic [ENT_W-1:0]  perm_val;
  logic [DATA_W-1:0] asm_val;
  logic [ID_W-1:0]   key_id;
  logic              slot_used, slot_hit, rd_match, out_free, load_data;
  logic [BUSES-1:0]  bus_open;

  assign bus      = cmd_q.bus;
  assign fill     = fill_q[bus];
  assign r_inc    = r_q + 1'b1;
  assign len_sat  = (cmd_q.len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : cmd_q.len;
  assign lim      = (limit_q > CNT_W'(PER_ID_DEPTH)) ? CNT_W'(PER_ID_DEPTH) : limit_q;
  assign perm_val = pvld_q[perm_addr_q] ? perm_rdata : perm_addr_q[ENT_W-1:0];
  assign asm_val  = wvld_q[asm_addr_q] ? asm_rdata : '0;
  assign key_id   = (state_q == ST_DS_CMP) ? hdr_id_q : cmd_q.id;
  assign slot_used = used_q[{bus, s_q}];
  assign slot_hit = slot_used && (slot_rdata.id == key_id);
  assign rd_match = (cmd_q.op == OP_READ_BUS) || (hdr_rdata.id == cmd_q.id);
  assign out_free = !out_valid_q || out_ready_i;
  assign load_data = (state_q == ST_OUT_LD) && out_free;

  always_comb begin
    for (int b = 0; b < BUSES; b++) begin
      bus_open[b] = cfg_valid_i && (cfg_index_i == CFG_BUS_ENABLE) &&
                    cfg_data_i[b] && !enable_q[b];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (q_valid_i) state_d = ST_DISP;
      ST_DISP: begin
        if (cmd_q.op == OP_BEAT) state_d = ST_BEAT;
        else if (cmd_q.op == OP_OFFLINE || fill == '0) state_d = ST_STAT;
        else state_d = ST_RD_PERM;
      end
      ST_BEAT:   state_d = cmd_q.last ? ST_SL_RD : ST_IDLE;
      ST_SL_RD:  state_d = ST_SL_CMP;
      ST_SL_CMP: begin
        if (slot_hit) state_d = ST_CHK;
        else if (s_q == SLOT_W'(ID_SLOTS - 1)) state_d = ST_SL_NEW;
        else state_d = ST_SL_RD;
      end
      ST_SL_NEW: state_d = free_vld_q ? ST_CHK : ST_CM_END;
      ST_CHK: begin
        if (cnt_q >= lim || fill >= (ENT_W + 1)'(ENT)) state_d = ST_CM_END;
        else state_d = ST_EP_RD;
      end
      ST_EP_RD:  state_d = ST_EP_GET;
      ST_EP_GET: state_d = ST_CP_RD;
      ST_CP_RD:  state_d = ST_CP_WR;
      ST_CP_WR:  state_d = (w_q == WORD_W'(WORDS - 1)) ? ST_CM_FIN : ST_CP_RD;
      ST_CM_FIN: state_d = ST_CM_END;
      ST_CM_END: state_d = ST_IDLE;
      ST_RD_PERM: state_d = ST_RD_HDR;
      ST_RD_HDR: state_d = ST_RD_CMP;
      ST_RD_CMP: begin
        if (rd_match) state_d = ST_OUT_RD;
        else if (r_inc == fill) state_d = ST_STAT;
        else state_d = ST_RD_PERM;
      end
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: begin
        if (out_free) state_d = (w_q == beats_m1_q) ? ST_SH_RD : ST_OUT_RD;
      end
      ST_SH_RD:  state_d = (r_inc < fill) ? ST_SH_WR : ST_DS_RD;
      ST_SH_WR:  state_d = ST_SH_RD;
      ST_DS_RD:  state_d = ST_DS_CMP;
      ST_DS_CMP: begin
        if (slot_hit || s_q == SLOT_W'(ID_SLOTS - 1)) state_d = ST_IDLE;
        else state_d = ST_DS_RD;
      end
      ST_STAT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    q_pop_o    = 1'b0;
    asm_we     = 1'b0;
    asm_re     = 1'b0;
    hdr_we     = 1'b0;
    hdr_re     = 1'b0;
    pay_we     = 1'b0;
    pay_re     = 1'b0;
    perm_we    = 1'b0;
    perm_re    = 1'b0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    asm_waddr  = {bus, beat_q[bus][WORD_W-1:0]};
    asm_wdata  = cmd_q.data;
    asm_raddr  = {bus, w_q};
    hdr_waddr  = {bus, ent_q};
    hdr_wdata  = '{id: cmd_q.id, len: len_sat};
    hdr_raddr  = {bus, perm_val};
    pay_waddr  = {bus, ent_q, w_q};
    pay_wdata  = mask_word(asm_val, len_sat, w_q);
    pay_raddr  = {bus, ent_q, w_q};
    perm_waddr = {bus, r_q[ENT_W-1:0]};
    perm_wdata = perm_val;
    perm_raddr = {bus, r_q[ENT_W-1:0]};
    slot_waddr = {bus, slot_idx_q};
    slot_wdata = '{id: cmd_q.id, cnt: cnt_q + 1'b1};
    slot_raddr = {bus, s_q};
    unique case (state_q)
      ST_IDLE:   q_pop_o = q_valid_i;
      ST_BEAT:   asm_we = 1'b1;
      ST_SL_RD, ST_DS_RD: slot_re = 1'b1;
      ST_SL_NEW: begin
        slot_we    = free_vld_q;
        slot_waddr = {bus, free_idx_q};
        slot_wdata = '{id: cmd_q.id, cnt: '0};
      end
      ST_EP_RD: begin
        perm_re    = 1'b1;
        perm_raddr = {bus, fill[ENT_W-1:0]};
      end
      ST_CP_RD: begin
        asm_re = 1'b1;
        hdr_we = 1'b1;
      end
      ST_CP_WR:   pay_we = 1'b1;
      ST_CM_FIN:  slot_we = 1'b1;
      ST_RD_PERM: perm_re = 1'b1;
      ST_RD_HDR:  hdr_re = 1'b1;
      ST_OUT_RD:  pay_re = 1'b1;
      ST_SH_RD: begin
        if (r_inc < fill) begin
          perm_re    = 1'b1;
          perm_raddr = {bus, r_inc[ENT_W-1:0]};
        end else begin
          // The removed entry goes to the free part of the order list.
          perm_we    = 1'b1;
          perm_wdata = ent_q;
        end
      end
      ST_SH_WR:  perm_we = 1'b1;
      ST_DS_CMP: begin
        slot_we    = slot_hit && (slot_rdata.cnt != '0);
        slot_waddr = {bus, s_q};
        slot_wdata = '{id: hdr_id_q, cnt: slot_rdata.cnt - 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= CNT_W'(PER_ID_DEPTH);
      enable_q    <= '0;
      wvld_q      <= '0;
      used_q      <= '0;
      pvld_q      <= '0;
      out_valid_q <= 1'b0;
      free_vld_q  <= 1'b0;
      for (int b = 0; b < BUS_N; b++) begin
        fill_q[b] <= '0;
        beat_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (perm_we) pvld_q[perm_waddr] <= 1'b1;
      unique case (state_q)
        ST_BEAT: begin
          wvld_q[asm_waddr] <= 1'b1;
          if (cmd_q.last) begin
            beat_q[bus] <= '0;
            free_vld_q  <= 1'b0;
          end else if (beat_q[bus] != 3'd7) begin
            beat_q[bus] <= beat_q[bus] + 1'b1;
          end
        end
        ST_SL_CMP: begin
          if (!slot_hit && !slot_used && !free_vld_q) free_vld_q <= 1'b1;
        end
        ST_SL_NEW: if (free_vld_q) used_q[{bus, free_idx_q}] <= 1'b1;
        ST_CM_FIN: fill_q[bus] <= fill + 1'b1;
        ST_CM_END: begin
          for (int i = 0; i < WORDS; i++) wvld_q[{bus, WORD_W'(i)}] <= 1'b0;
        end
        ST_SH_RD:  if (!(r_inc < fill)) fill_q[bus] <= fill - 1'b1;
        default: ;
      endcase
      if (load_data || (state_q == ST_STAT && out_free)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_index_i == CFG_PER_ID_LIMIT) limit_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_BUS_ENABLE) enable_q <= cfg_data_i[BUSES-1:0];
      // Open a bus with an empty store.
      for (int b = 0; b < BUSES; b++) begin
        if (bus_open[b]) begin
          fill_q[b] <= '0;
          beat_q[b] <= '0;
          for (int i = 0; i < WORDS; i++) wvld_q[{BUS_W'(b), WORD_W'(i)}] <= 1'b0;
          for (int s = 0; s < ID_SLOTS; s++) used_q[{BUS_W'(b), SLOT_W'(s)}] <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    if (perm_re) perm_addr_q <= perm_raddr;
    if (asm_re) asm_addr_q <= asm_raddr;
    unique case (state_q)
      ST_DISP: begin
        r_q    <= '0;
        stat_q <= (cmd_q.op == OP_OFFLINE) ? STAT_OFFLINE : STAT_EMPTY;
      end
      ST_BEAT: s_q <= '0;
      ST_SL_CMP: begin
        if (slot_hit) begin
          slot_idx_q <= s_q;
          cnt_q      <= slot_rdata.cnt;
        end else begin
          if (!slot_used && !free_vld_q) free_idx_q <= s_q;
          s_q <= s_q + 1'b1;
        end
      end
      ST_SL_NEW: begin
        slot_idx_q <= free_idx_q;
        cnt_q      <= '0;
      end
      ST_EP_GET: begin
        ent_q <= perm_val;
        w_q   <= '0;
      end
      ST_CP_WR:  w_q <= w_q + 1'b1;
      ST_RD_HDR: ent_q <= perm_val;
      ST_RD_CMP: begin
        if (rd_match) begin
          hdr_id_q   <= hdr_rdata.id;
          hdr_len_q  <= hdr_rdata.len;
          w_q        <= '0;
          beats_m1_q <= (hdr_rdata.len == '0) ? '0 : WORD_W'((hdr_rdata.len - 1'b1) >> 3);
        end else begin
          r_q <= r_inc;
        end
      end
      ST_OUT_LD: if (out_free) w_q <= w_q + 1'b1;
      ST_SH_RD:  if (!(r_inc < fill)) s_q <= '0;
      ST_SH_WR:  r_q <= r_inc;
      ST_DS_CMP: s_q <= s_q + 1'b1;
      default: ;
    endcase
    if (load_data) begin
      status_q   <= STAT_OK;
      id_res_q   <= hdr_id_q;
      len_res_q  <= hdr_len_q;
      data_res_q <= pay_rdata;
      last_q     <= (w_q == beats_m1_q);
    end else if (state_q == ST_STAT && out_free) begin
      status_q   <= stat_q;
      id_res_q   <= '0;
      len_res_q  <= '0;
      data_res_q <= '0;
      last_q     <= 1'b1;
    end
  end

  crxfb_ram #(.Width(DATA_W), .Depth(ASM_DEPTH)) u_asm_ram (
    .clk_i, .we_i(asm_we), .waddr_i(asm_waddr), .wdata_i(asm_wdata),
    .re_i(asm_re), .raddr_i(asm_raddr), .rdata_o(asm_rdata)
  );

  crxfb_ram #(.Width($bits(hdr_t)), .Depth(HDR_DEPTH)) u_hdr_ram (
    .clk_i, .we_i(hdr_we), .waddr_i(hdr_waddr), .wdata_i(hdr_wdata),
    .re_i(hdr_re), .raddr_i(hdr_raddr), .rdata_o(hdr_rdata)
  );

  crxfb_ram #(.Width(DATA_W), .Depth(PAY_DEPTH)) u_pay_ram (
    .clk_i, .we_i(pay_we), .waddr_i(pay_waddr), .wdata_i(pay_wdata),
    .re_i(pay_re), .raddr_i(pay_raddr), .rdata_o(pay_rdata)
  );

  crxfb_ram #(.Width(ENT_W), .Depth(HDR_DEPTH)) u_perm_ram (
    .clk_i, .we_i(perm_we), .waddr_i(perm_waddr), .wdata_i(perm_wdata),
    .re_i(perm_re), .raddr_i(perm_raddr), .rdata_o(perm_rdata)
  );

  crxfb_ram #(.Width($bits(slot_t)), .Depth(SLOT_DEPTH)) u_slot_ram (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .re_i(slot_re), .raddr_i(slot_raddr), .rdata_o(slot_rdata)
  );

  assign bus_enable_o    = enable_q;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign can_id_res_o    = id_res_q;
  assign length_res_o    = len_res_q;
  assign data_word_res_o = data_res_q;
  assign last_o          = last_q;

  a_slot_claimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHK |-> used_q[{bus, slot_idx_q}])
    else $error("limit check without a claimed slot");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> fill <= (ENT_W + 1)'(ENT))
    else $error("bus store over capacity");

  a_beat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT_LD |-> w_q <= beats_m1_q)
    else $error("result beat past the frame end");

  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STAT |-> stat_q != STAT_OK)
    else $error("status reply without error code");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SH_WR |-> r_inc < fill)
    else $error("order shift beyond fill");

endmodule

// ===== rtl/can_rx_per_id_frame_buffer_core.sv =====
// Receive buffer for up to four CAN buses with one queue per CAN ID.
// Input channel (in_valid_i/in_ready_o): receive beats, read-by-ID and
// read-oldest-on-bus requests. Output channel (out_valid_o/out_ready_i):
// result beats; a read returns one to eight beats, the last one marked.
// Config channel (cfg_*): register 0 per_id_limit, register 1 bus_enable;
// setting a bus_enable bit empties that bus. cfg_ready_o is always high.
// Items pass a two-entry queue into a single sequencer, so the input side
// keeps taking items while a result waits at the output register.
// Items are worked off one at a time by RAM walks in the sequencer: a receive
// beat writes the assembly buffer; a final beat also searches the slots and
// copies eight words; a read scans ranks, sends its beats, shifts younger
// frames and searches the slots.
// A stalled receiver holds the sequencer at the output register; the queue
// then fills and in_ready_o drops. Reset clears all buses and bookkeeping
// at once: no clearing pass.
module can_rx_per_id_frame_buffer_core
  import crxfb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [BUS_W-1:0]      bus_i,
  input  logic [ID_W-1:0]       can_id_i,
  input  logic [LEN_W-1:0]      length_i,
  input  logic [DATA_W-1:0]     data_word_i,
  input  logic                  beat_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [ID_W-1:0]       can_id_res_o,
  output logic [LEN_W-1:0]      length_res_o,
  output logic [DATA_W-1:0]     data_word_res_o,
  output logic                  last_o
);

  logic             q_full, q_push, q_valid, q_pop;
  cmd_t             push_cmd, pop_cmd;
  logic [BUSES-1:0] bus_enable;

  assign cfg_ready_o = 1'b1;

  crxfb_front u_front (
    .in_valid_i, .in_ready_o, .kind_i, .bus_i, .can_id_i, .length_i,
    .data_word_i, .beat_last_i,
    .bus_enable_i(bus_enable),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_cmd_o(push_cmd)
  );

  crxfb_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .cmd_i(push_cmd), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .cmd_o(pop_cmd)
  );

  crxfb_back u_back (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .bus_enable_o(bus_enable),
    .q_valid_i(q_valid), .q_cmd_i(pop_cmd), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .status_o, .can_id_res_o, .length_res_o,
    .data_word_res_o, .last_o
  );

endmodule

// ===== sim/tb_can_rx_per_id_frame_buffer_core.sv =====
module tb_can_rx_per_id_frame_buffer_core;
  import crxfb_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 5000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data [WORDS];
  } frame_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BUS_W-1:0]  bus;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              typed;
    stat_e             status;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            kind_i = '0;
  logic [BUS_W-1:0]      bus_i = '0;
  logic [ID_W-1:0]       can_id_i = '0;
  logic [LEN_W-1:0]      length_i = '0;
  logic [DATA_W-1:0]     data_word_i = '0;
  logic                  beat_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [ID_W-1:0]       can_id_res_o;
  logic [LEN_W-1:0]      length_res_o;
  logic [DATA_W-1:0]     data_word_res_o;
  logic                  last_o;

  can_rx_per_id_frame_buffer_core DUT (.*);

  // Shadow of the buffer
  logic [4:0]        limit_reg;
  logic [3:0]        enable_reg;
  frame_t            bus_frames [BUSES][$];
  logic              slot_used [BUSES][ID_SLOTS];
  logic [ID_W-1:0]   slot_id [BUSES][ID_SLOTS];
  int                slot_cnt [BUSES][ID_SLOTS];
  int                asm_beat [BUSES];
  logic [DATA_W-1:0] asm_buf [BUSES][WORDS];

  beat_t pending_beats [$];
  int    err_cnt = 0;
  int    idle_cycles = 0;
  int    burst_left = 0;
  int    hold_req = 0;
  int    hold_seen = 0;
  row_t  dir_tab [23];
  logic [ID_W-1:0] id_pool [6];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  function automatic void clear_bus(input int b);
    bus_frames[b].delete();
    for (int s = 0; s < ID_SLOTS; s++) begin
      slot_used[b][s] = 1'b0;
      slot_cnt[b][s] = 0;
    end
    for (int w = 0; w < WORDS; w++) asm_buf[b][w] = '0;
    asm_beat[b] = 0;
  endfunction

  function automatic int find_slot(input int b, input logic [ID_W-1:0] id);
    for (int s = 0; s < ID_SLOTS; s++)
      if (slot_used[b][s] && slot_id[b][s] == id) return s;
    return -1;
  endfunction

  function automatic void store_frame(input int b, input logic [ID_W-1:0] id,
                                      input int len);
    frame_t f;
    int s;
    int lim;
    s = find_slot(b, id);
    if (s < 0) begin
      for (int i = 0; i < ID_SLOTS && s < 0; i++)
        if (!slot_used[b][i]) s = i;
      if (s < 0) return;
      // the slot stays taken even if the frame drops below
      slot_used[b][s] = 1'b1;
      slot_id[b][s] = id;
      slot_cnt[b][s] = 0;
    end
    lim = (limit_reg > PER_ID_DEPTH) ? PER_ID_DEPTH : limit_reg;
    if (slot_cnt[b][s] >= lim || bus_frames[b].size() >= ENT) return;
    f.id = id;
    f.len = LEN_W'(len);
    for (int w = 0; w < WORDS; w++) begin
      f.data[w] = asm_buf[b][w];
      for (int j = 0; j < 8; j++)
        if (w * 8 + j >= len) f.data[w][j*8 +: 8] = 8'h00;
    end
    bus_frames[b].push_back(f);
    slot_cnt[b][s]++;
  endfunction

  function automatic void push_status(input stat_e st);
    beat_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    pending_beats.push_back(r);
  endfunction

  function automatic void predict_item(input row_t it);
    int b;
    int idx;
    int len;
    int beats;
    int s;
    frame_t f;
    beat_t r;
    b = it.bus;
    if (it.kind == KIND_NONE) return;
    if (it.kind == KIND_RX) begin
      if (!enable_reg[b]) return;
      asm_buf[b][asm_beat[b]] = it.data;
      if (it.last) begin
        len = (it.len > MAX_BYTES) ? MAX_BYTES : it.len;
        store_frame(b, it.id, len);
        for (int w = 0; w < WORDS; w++) asm_buf[b][w] = '0;
        asm_beat[b] = 0;
      end else if (asm_beat[b] < 7) begin
        asm_beat[b]++;
      end
      return;
    end
    if (!enable_reg[b]) begin
      push_status(STAT_OFFLINE);
      return;
    end
    idx = -1;
    for (int e = 0; e < bus_frames[b].size() && idx < 0; e++)
      if (it.kind == KIND_RD_BUS || bus_frames[b][e].id == it.id) idx = e;
    if (idx < 0) begin
      push_status(STAT_EMPTY);
      return;
    end
    f = bus_frames[b][idx];
    beats = (f.len + 7) / 8;
    if (beats == 0) beats = 1;
    for (int w = 0; w < beats; w++) begin
      r.status = STAT_OK;
      r.id = f.id;
      r.len = f.len;
      r.data = f.data[w];
      r.last = (w + 1 == beats);
      pending_beats.push_back(r);
    end
    bus_frames[b].delete(idx);
    s = find_slot(b, f.id);
    if (s >= 0 && slot_cnt[b][s] > 0) slot_cnt[b][s]--;
  endfunction

  // Check result beats in order
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        report("unexpected item", data_word_res_o, '0);
      end else begin
        want = pending_beats.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (can_id_res_o !== want.id) report("can_id", can_id_res_o, want.id);
        if (length_res_o !== want.len) report("length", length_res_o, want.len);
        if (data_word_res_o !== want.data) report("data", data_word_res_o, want.data);
        if (last_o !== want.last) report("last", last_o, want.last);
      end
    end
  end

  // Receiver: changing stall pattern, with long hold-offs on request
  always @(posedge clk_i) begin
    int hold_left;
    int mode;
    int phase_cnt;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      mode = 0;
      phase_cnt = 0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (phase_cnt == 0) begin
        mode = $urandom_range(0, 2);
        phase_cnt = $urandom_range(20, 80);
      end
      phase_cnt--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (mode == 0) begin
        out_ready_i <= 1'b1;
      end else if (mode == 1) begin
        out_ready_i <= ($urandom_range(0, 1) == 1);
      end else begin
        out_ready_i <= (phase_cnt % 4 != 0);
      end
    end
  end

  // Watchdog on cycles without progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT_CYCLES) begin
      $display("FAIL can_rx_per_id_frame_buffer_core");
      $finish;
    end
  end

  task automatic send_item(input row_t it);
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    bus_i <= it.bus;
    can_id_i <= it.id;
    length_i <= it.len;
    data_word_i <= it.data;
    beat_last_i <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.typed) begin
      predict_item(it);
      pending_beats.delete(pending_beats.size() - 1);
      push_status(it.status);
    end else begin
      predict_item(it);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [3:0] nv;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PER_ID_LIMIT) begin
      limit_reg = 5'(value);
    end else begin
      nv = 4'(value);
      for (int b = 0; b < BUSES; b++)
        if (nv[b] && !enable_reg[b]) clear_bus(b);
      enable_reg = nv;
    end
    @(posedge clk_i);
  endtask

  function automatic row_t make_row(input logic [1:0] kind, input int bus,
                                    input logic [ID_W-1:0] id, input int len,
                                    input logic [DATA_W-1:0] data, input logic last);
    row_t r;
    r = '0;
    r.kind = kind;
    r.bus = BUS_W'(bus);
    r.id = id;
    r.len = LEN_W'(len);
    r.data = data;
    r.last = last;
    r.status = STAT_OK;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 4) == 0) return ID_W'($urandom());
    return id_pool[$urandom_range(0, 5)];
  endfunction

  // Frame of random beats and content
  task automatic send_frame(input int bus);
    logic [ID_W-1:0] id;
    int nb;
    int len;
    id = pick_id();
    nb = $urandom_range(1, 9);
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, nb * 8);
    for (int i = 0; i < nb; i++)
      send_item(make_row(KIND_RX, bus, id, len, rand_word(), i == nb - 1));
  endtask

  task automatic random_phase(input int n);
    int bus;
    int pick;
    for (int i = 0; i < n; i++) begin
      bus = $urandom_range(0, 3);
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        send_frame(bus);
      end else if (pick < 16) begin
        send_item(make_row(KIND_RD_ID, bus, pick_id(), $urandom_range(0, 127),
                           rand_word(), $urandom_range(0, 1)));
      end else if (pick < 18) begin
        send_item(make_row(KIND_RD_BUS, bus, ID_W'($urandom()), $urandom_range(0, 127),
                           rand_word(), $urandom_range(0, 1)));
      end else begin
        // noise: any kind, any field
        send_item(make_row(2'($urandom_range(0, 3)), bus, ID_W'($urandom()),
                           $urandom_range(0, 127), rand_word(), $urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    limit_reg = 5'd16;
    enable_reg = '0;
    for (int b = 0; b < BUSES; b++) clear_bus(b);
    for (int i = 0; i < 6; i++) id_pool[i] = ID_W'($urandom());
    id_pool[0] = '0;
    id_pool[1] = '1;
    dir_tab[0] = make_row(KIND_RD_BUS, 3, '0, 0, '0, 1'b0);
    dir_tab[0].typed = 1'b1;
    dir_tab[0].status = STAT_OFFLINE;
    dir_tab[1] = make_row(KIND_RD_ID, 3, '1, 127, '1, 1'b1);
    dir_tab[1].typed = 1'b1;
    dir_tab[1].status = STAT_OFFLINE;
    dir_tab[2] = make_row(KIND_RD_BUS, 0, '0, 0, '0, 1'b0);
    dir_tab[2].typed = 1'b1;
    dir_tab[2].status = STAT_EMPTY;
    dir_tab[3] = make_row(KIND_RX, 3, 29'd5, 8, '1, 1'b1);
    dir_tab[4] = make_row(KIND_RX, 0, '1, 0, '1, 1'b1);
    dir_tab[5] = make_row(KIND_RD_BUS, 0, '0, 0, '0, 1'b0);
    dir_tab[6] = make_row(KIND_RX, 1, 29'd7, 3, '1, 1'b0);
    dir_tab[7] = make_row(KIND_RX, 1, 29'd7, 11, 64'h0123_4567_89ab_cdef, 1'b1);
    dir_tab[8] = make_row(KIND_RX, 1, 29'd7, 127, '1, 1'b1);
    dir_tab[9] = make_row(KIND_RD_ID, 1, 29'd7, 0, '0, 1'b0);
    dir_tab[10] = make_row(KIND_RD_ID, 1, 29'd7, 0, '0, 1'b0);
    dir_tab[11] = make_row(KIND_RD_ID, 1, 29'd7, 0, '0, 1'b0);
    dir_tab[11].typed = 1'b1;
    dir_tab[11].status = STAT_EMPTY;
    dir_tab[12] = make_row(KIND_NONE, 1, '1, 64, '1, 1'b1);
    // nine beats: the last two share word 7
    for (int i = 0; i < 9; i++)
      dir_tab[13 + i] = make_row(KIND_RX, 2, 29'h0ABC_DEF0, 64,
                                 {32'hC0DE_0000, 32'(i)}, i == 8);
    dir_tab[22] = make_row(KIND_RD_BUS, 2, '0, 0, '0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_BUS_ENABLE, 4'b0111);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain_results();

    write_reg(CFG_BUS_ENABLE, 4'b1111);
    random_phase(2);
    drain_results();
    write_reg(CFG_PER_ID_LIMIT, 1);
    random_phase(2);
    drain_results();
    write_reg(CFG_PER_ID_LIMIT, 0);
    write_reg(CFG_BUS_ENABLE, 4'b1010);
    random_phase(2);
    drain_results();
    write_reg(CFG_PER_ID_LIMIT, 31);
    write_reg(CFG_BUS_ENABLE, 4'b1111);
    random_phase(2);
    drain_results();

    // Exhaust the slots and fill bus 0, then stall the output
    write_reg(CFG_PER_ID_LIMIT, 16);
    write_reg(CFG_BUS_ENABLE, 4'b1110);
    write_reg(CFG_BUS_ENABLE, 4'b1111);
    for (int i = 0; i < 17; i++)
      send_item(make_row(KIND_RX, 0, ID_W'(1000 + i), 8, rand_word(), 1'b1));
    for (int i = 0; i < 49; i++)
      send_item(make_row(KIND_RX, 0, ID_W'(1000 + i % 5), $urandom_range(0, 16),
                         rand_word(), 1'b1));
    hold_req++;
    for (int i = 0; i < 12; i++)
      send_item(make_row(i % 3 == 0 ? KIND_RD_ID : KIND_RD_BUS, 0,
                         ID_W'(1000 + i % 6), 0, '0, 1'b0));
    drain_results();

    write_reg(CFG_PER_ID_LIMIT, $urandom_range(1, 16));
    write_reg(CFG_BUS_ENABLE, $urandom_range(0, 15));
    random_phase(2);
    drain_results();
    write_reg(CFG_BUS_ENABLE, 4'b0000);
    write_reg(CFG_BUS_ENABLE, 4'b1111);
    random_phase(2);
    drain_results();

    if (err_cnt == 0) begin
      $display("PASS can_rx_per_id_frame_buffer_core");
    end else begin
      $display("FAIL can_rx_per_id_frame_buffer_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/crxfb_pkg.sv
rtl/crxfb_ram.sv
rtl/crxfb_front.sv
rtl/crxfb_queue.sv
rtl/crxfb_back.sv
rtl/can_rx_per_id_frame_buffer_core.sv
sim/tb_can_rx_per_id_frame_buffer_core.sv
